>>> design/rotation_matrix_to_quaternion_core_macros.svh
// Assertion helpers used by the FIFO.
`ifndef ROTATION_MATRIX_TO_QUATERNION_CORE_MACROS_SVH
`define ROTATION_MATRIX_TO_QUATERNION_CORE_MACROS_SVH

// Condition must never hold outside reset.
`define RMQ_ASSERT_NEVER(lbl, clk, rst_n, cond) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error("assertion failed");

// Antecedent in one cycle implies consequent in the next.
`define RMQ_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

>>> design/rmq_pkg.sv
`default_nettype none
package rmq_pkg;
    localparam int RMQ_FRAC_BITS  = 14;
    localparam int RMQ_DATA_W     = 16;
    localparam int RMQ_NUM_W      = 17;
    localparam int RMQ_QUO_W      = 17;
    localparam int RMQ_EPS_W      = 14;
    localparam int RMQ_FIFO_DEPTH = 4;

    localparam logic signed [RMQ_DATA_W-1:0] RMQ_Q_MAX = 16'sh7FFF;
    localparam logic signed [RMQ_DATA_W-1:0] RMQ_Q_MIN = 16'sh8000;

    // Branch codes
    localparam logic [1:0] BR_TRACE = 2'd0;
    localparam logic [1:0] BR_XMAJ  = 2'd1;
    localparam logic [1:0] BR_YMAJ  = 2'd2;
    localparam logic [1:0] BR_ZMAJ  = 2'd3;

    typedef logic signed [RMQ_NUM_W-1:0] t_num;

    typedef struct packed {
        logic [1:0] branch;
        t_num       n0;
        t_num       n1;
        t_num       n2;
    } t_job;

    typedef struct packed {
        logic [1:0]                   branch;
        logic signed [RMQ_DATA_W-1:0] diag;
    } t_tag;
endpackage
`default_nettype wire

>>> design/rmq_front.sv
`default_nettype none
module rmq_front #(
    parameter int FRAC_BITS = rmq_pkg::RMQ_FRAC_BITS,
    parameter int RAD_W     = 17
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_valid,
    output logic                                   o_ready,
    input  logic signed [rmq_pkg::RMQ_DATA_W-1:0]  i_m11,
    input  logic signed [rmq_pkg::RMQ_DATA_W-1:0]  i_m12,
    input  logic signed [rmq_pkg::RMQ_DATA_W-1:0]  i_m13,
    input  logic signed [rmq_pkg::RMQ_DATA_W-1:0]  i_m21,
    input  logic signed [rmq_pkg::RMQ_DATA_W-1:0]  i_m22,
    input  logic signed [rmq_pkg::RMQ_DATA_W-1:0]  i_m23,
    input  logic signed [rmq_pkg::RMQ_DATA_W-1:0]  i_m31,
    input  logic signed [rmq_pkg::RMQ_DATA_W-1:0]  i_m32,
    input  logic signed [rmq_pkg::RMQ_DATA_W-1:0]  i_m33,
    input  logic [rmq_pkg::RMQ_EPS_W-1:0]          i_eps,
    output logic                                   o_valid,
    input  logic                                   i_ready,
    output rmq_pkg::t_job                          o_job,
    output logic [RAD_W-1:0]                       o_rad
);
    import rmq_pkg::*;

    localparam int SUM_W = RAD_W + 1;
    localparam logic signed [SUM_W-1:0] ONE = SUM_W'(1) <<< FRAC_BITS;

    logic signed [SUM_W-1:0] e11, e22, e33, eps_ext, tr, rsel;
    logic                    use_tr, xmaj, ymaj;
    t_job                    job;
    logic [RAD_W-1:0]        rad;
    logic                    r_valid;
    t_job                    r_job;
    logic [RAD_W-1:0]        r_rad;

    assign e11     = SUM_W'(i_m11);
    assign e22     = SUM_W'(i_m22);
    assign e33     = SUM_W'(i_m33);
    assign eps_ext = $signed(SUM_W'(i_eps));
    assign tr      = ONE + e11 + e22 + e33;
    assign use_tr  = tr > eps_ext;
    assign xmaj    = (i_m11 > i_m22) && (i_m11 > i_m33);
    assign ymaj    = i_m22 > i_m33;

    always_comb begin
        if (use_tr) begin
            job.branch = BR_TRACE;
            rsel       = tr;
            job.n0     = t_num'(i_m12) - t_num'(i_m21);
            job.n1     = t_num'(i_m31) - t_num'(i_m13);
            job.n2     = t_num'(i_m23) - t_num'(i_m32);
        end else if (xmaj) begin
            job.branch = BR_XMAJ;
            rsel       = ONE + e11 - e22 - e33;
            job.n0     = t_num'(i_m12) + t_num'(i_m21);
            job.n1     = t_num'(i_m31) + t_num'(i_m13);
            job.n2     = t_num'(i_m23) - t_num'(i_m32);
        end else if (ymaj) begin
            job.branch = BR_YMAJ;
            rsel       = ONE + e22 - e11 - e33;
            job.n0     = t_num'(i_m12) + t_num'(i_m21);
            job.n1     = t_num'(i_m23) + t_num'(i_m32);
            job.n2     = t_num'(i_m31) - t_num'(i_m13);
        end else begin
            job.branch = BR_ZMAJ;
            rsel       = ONE + e33 - e11 - e22;
            job.n0     = t_num'(i_m31) + t_num'(i_m13);
            job.n1     = t_num'(i_m23) + t_num'(i_m32);
            job.n2     = t_num'(i_m12) - t_num'(i_m21);
        end
    end

    // Clamp a non-positive radicand to zero
    assign rad = (rsel <= 0) ? '0 : rsel[RAD_W-1:0];

    assign o_ready = !r_valid || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_job <= job;
            r_rad <= rad;
        end
    end

    assign o_valid = r_valid;
    assign o_job   = r_job;
    assign o_rad   = r_rad;
endmodule
`default_nettype wire

>>> design/rmq_fifo.sv
`default_nettype none
`include "rotation_matrix_to_quaternion_core_macros.svh"
module rmq_fifo #(
    parameter int DATA_W = 8,
    parameter int DEPTH  = rmq_pkg::RMQ_FIFO_DEPTH
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  logic [DATA_W-1:0] i_data,
    input  logic              i_pop,
    output logic [DATA_W-1:0] o_data,
    output logic              o_full,
    output logic              o_empty
);
    import rmq_pkg::*;

    localparam int AW = $clog2(DEPTH);

    logic [DATA_W-1:0] r_mem [DEPTH];
    logic [AW:0]       r_wr, r_rd;
    logic [AW:0]       cnt;

    assign cnt     = r_wr - r_rd;
    assign o_full  = cnt == (AW+1)'(DEPTH);
    assign o_empty = cnt == '0;
    assign o_data  = r_mem[r_rd[AW-1:0]];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr <= '0;
            r_rd <= '0;
        end else begin
            if (i_push) begin
                r_wr <= r_wr + 1'b1;
            end
            if (i_pop) begin
                r_rd <= r_rd + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr[AW-1:0]] <= i_data;
        end
    end

    `RMQ_ASSERT_NEVER(a_depth_bound, i_clk, i_rst_n, cnt > (AW+1)'(DEPTH))
    `RMQ_ASSERT_NEXT(a_push_fills, i_clk, i_rst_n, i_push && !i_pop, !o_empty)
    `RMQ_ASSERT_NEXT(a_last_drains, i_clk, i_rst_n, i_pop && !i_push && cnt == (AW+1)'(1), o_empty)
endmodule
`default_nettype wire

>>> design/rmq_sqrt.sv
`default_nettype none
module rmq_sqrt #(
    parameter int FRAC_BITS = rmq_pkg::RMQ_FRAC_BITS,
    parameter int RAD_W     = 17,
    parameter int ROOT_W    = 16
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_en,
    input  logic              i_valid,
    input  rmq_pkg::t_job     i_job,
    input  logic [RAD_W-1:0]  i_rad,
    output logic              o_valid,
    output rmq_pkg::t_job     o_job,
    output logic [ROOT_W-1:0] o_root
);
    import rmq_pkg::*;

    localparam int RR_W  = 2 * ROOT_W;
    localparam int REM_W = ROOT_W + 2;

    logic              r_v  [ROOT_W];
    t_job              r_jb [ROOT_W];
    logic [RR_W-1:0]   r_rd [ROOT_W];
    logic [REM_W-1:0]  r_rm [ROOT_W];
    logic [ROOT_W-1:0] r_rt [ROOT_W];

    // One root bit per stage, most significant first
    for (genvar k = 0; k < ROOT_W; k++) begin : g_stage
        localparam int B = ROOT_W - 1 - k;
        logic              v_in;
        t_job              jb_in;
        logic [RR_W-1:0]   rd_in;
        logic [REM_W-1:0]  rm_in, rm_sh, trial;
        logic [ROOT_W-1:0] rt_in;

        if (k == 0) begin : g_first
            assign v_in  = i_valid;
            assign jb_in = i_job;
            assign rd_in = RR_W'(i_rad) << FRAC_BITS;
            assign rm_in = '0;
            assign rt_in = '0;
        end else begin : g_next
            assign v_in  = r_v[k-1];
            assign jb_in = r_jb[k-1];
            assign rd_in = r_rd[k-1];
            assign rm_in = r_rm[k-1];
            assign rt_in = r_rt[k-1];
        end

        assign rm_sh = {rm_in[REM_W-3:0], rd_in[2*B+1 -: 2]};
        assign trial = {rt_in, 2'b01};

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[k] <= 1'b0;
            end else if (i_en) begin
                r_v[k] <= v_in;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_jb[k] <= jb_in;
                r_rd[k] <= rd_in;
                if (rm_sh >= trial) begin
                    r_rm[k] <= rm_sh - trial;
                    r_rt[k] <= {rt_in[ROOT_W-2:0], 1'b1};
                end else begin
                    r_rm[k] <= rm_sh;
                    r_rt[k] <= {rt_in[ROOT_W-2:0], 1'b0};
                end
            end
        end
    end

    assign o_valid = r_v[ROOT_W-1];
    assign o_job   = r_jb[ROOT_W-1];
    assign o_root  = r_rt[ROOT_W-1];
endmodule
`default_nettype wire

>>> design/rmq_div.sv
`default_nettype none
module rmq_div #(
    parameter int FRAC_BITS = rmq_pkg::RMQ_FRAC_BITS,
    parameter int S_W       = 17
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_en,
    input  logic                                  i_valid,
    input  rmq_pkg::t_tag                         i_tag,
    input  logic [S_W-1:0]                        i_s,
    input  rmq_pkg::t_num                         i_num [3],
    output logic                                  o_valid,
    output rmq_pkg::t_tag                         o_tag,
    output logic signed [rmq_pkg::RMQ_DATA_W-1:0] o_quo [3]
);
    import rmq_pkg::*;

    localparam int QB   = RMQ_QUO_W;
    localparam int NW   = RMQ_NUM_W + FRAC_BITS;
    localparam int DR_W = S_W + 1;
    localparam logic [QB-1:0] POS_LIM = QB'(32767);
    localparam logic [QB-1:0] NEG_LIM = QB'(32768);

    logic            r_v  [QB];
    t_tag            r_tg [QB];
    logic [S_W-1:0]  r_s  [QB];
    logic [DR_W-1:0] r_rm [3][QB];
    logic [QB-1:0]   r_q  [3][QB];
    logic [QB-1:0]   r_nl [3][QB];
    logic            r_ng [3][QB];
    logic            r_ov [3][QB];

    for (genvar k = 0; k < QB; k++) begin : g_stage
        localparam int B = QB - 1 - k;
        logic           v_in;
        t_tag           tg_in;
        logic [S_W-1:0] s_in;

        if (k == 0) begin : g_first
            assign v_in  = i_valid;
            assign tg_in = i_tag;
            assign s_in  = i_s;
        end else begin : g_next
            assign v_in  = r_v[k-1];
            assign tg_in = r_tg[k-1];
            assign s_in  = r_s[k-1];
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[k] <= 1'b0;
            end else if (i_en) begin
                r_v[k] <= v_in;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_tg[k] <= tg_in;
                r_s[k]  <= s_in;
            end
        end

        for (genvar l = 0; l < 3; l++) begin : g_lane
            logic [DR_W-1:0]       rm_in, rm_sh;
            logic [QB-1:0]         q_in, nl_in;
            logic                  ng_in, ov_in;
            logic [RMQ_NUM_W-1:0]  mag;
            logic [NW-1:0]         dvd, hi;

            if (k == 0) begin : g_first
                // Overflow when the quotient would need more than QB bits
                assign mag   = i_num[l][RMQ_NUM_W-1] ? RMQ_NUM_W'(-i_num[l])
                                                     : RMQ_NUM_W'(i_num[l]);
                assign dvd   = {mag, FRAC_BITS'(0)};
                assign hi    = dvd >> QB;
                assign ov_in = hi >= NW'(i_s);
                assign rm_in = hi[DR_W-1:0];
                assign nl_in = dvd[QB-1:0];
                assign ng_in = i_num[l][RMQ_NUM_W-1];
                assign q_in  = '0;
            end else begin : g_next
                assign mag   = '0;
                assign dvd   = '0;
                assign hi    = '0;
                assign ov_in = r_ov[l][k-1];
                assign rm_in = r_rm[l][k-1];
                assign nl_in = r_nl[l][k-1];
                assign ng_in = r_ng[l][k-1];
                assign q_in  = r_q[l][k-1];
            end

            assign rm_sh = {rm_in[DR_W-2:0], nl_in[B]};

            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_nl[l][k] <= nl_in;
                    r_ng[l][k] <= ng_in;
                    r_ov[l][k] <= ov_in;
                    if (rm_sh >= DR_W'(s_in)) begin
                        r_rm[l][k] <= rm_sh - DR_W'(s_in);
                        r_q[l][k]  <= {q_in[QB-2:0], 1'b1};
                    end else begin
                        r_rm[l][k] <= rm_sh;
                        r_q[l][k]  <= {q_in[QB-2:0], 1'b0};
                    end
                end
            end
        end
    end

    // Sign, saturate, and zero on a zero divisor
    for (genvar l = 0; l < 3; l++) begin : g_out
        logic [QB-1:0] q;
        logic          ov, ng;

        assign q  = r_q[l][QB-1];
        assign ov = r_ov[l][QB-1];
        assign ng = r_ng[l][QB-1];

        always_comb begin
            if (r_s[QB-1] == '0) begin
                o_quo[l] = '0;
            end else if (ng) begin
                if (ov || q > NEG_LIM) begin
                    o_quo[l] = RMQ_Q_MIN;
                end else begin
                    o_quo[l] = RMQ_DATA_W'(-$signed({1'b0, q}));
                end
            end else if (ov || q > POS_LIM) begin
                o_quo[l] = RMQ_Q_MAX;
            end else begin
                o_quo[l] = $signed(q[RMQ_DATA_W-1:0]);
            end
        end
    end

    assign o_valid = r_v[QB-1];
    assign o_tag   = r_tg[QB-1];
endmodule
`default_nettype wire

>>> design/rotation_matrix_to_quaternion_core.sv
// Rotation matrix to quaternion converter (trace / Shepperd method). Takes the
// nine elements of a 3x3 rotation matrix in signed fixed point (Q2.14 at the
// default FRAC_BITS) and returns quaternion x, y, z, w in the same format,
// saturated to 16 bits. One request is accepted per clock and one result is
// delivered per clock while the queue is not full and results are taken;
// each request passes through the square root pipeline (one root bit
// per stage) followed by the 17-stage divider that serves the three
// off-diagonal components in parallel. A front stage picks the branch
// (trace branch when one plus the trace exceeds trace_epsilon, else the
// largest diagonal element), forms the radicand and numerators, and
// hands them through a four-entry queue so that input and output stall on
// their own. A negative radicand gives S of zero and all quotients zero.
// trace_epsilon (reset 1) sits at APB byte address 0 and should only be
// written while the block is idle.
`default_nettype none
module rotation_matrix_to_quaternion_core #(
    parameter int FRAC_BITS = rmq_pkg::RMQ_FRAC_BITS
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    // Matrix request channel
    input  logic                                  i_valid,
    output logic                                  o_ready,
    input  logic signed [rmq_pkg::RMQ_DATA_W-1:0] i_m11,
    input  logic signed [rmq_pkg::RMQ_DATA_W-1:0] i_m12,
    input  logic signed [rmq_pkg::RMQ_DATA_W-1:0] i_m13,
    input  logic signed [rmq_pkg::RMQ_DATA_W-1:0] i_m21,
    input  logic signed [rmq_pkg::RMQ_DATA_W-1:0] i_m22,
    input  logic signed [rmq_pkg::RMQ_DATA_W-1:0] i_m23,
    input  logic signed [rmq_pkg::RMQ_DATA_W-1:0] i_m31,
    input  logic signed [rmq_pkg::RMQ_DATA_W-1:0] i_m32,
    input  logic signed [rmq_pkg::RMQ_DATA_W-1:0] i_m33,
    // Quaternion result channel
    output logic                                  o_valid,
    input  logic                                  i_ready,
    output logic signed [rmq_pkg::RMQ_DATA_W-1:0] o_quat_x,
    output logic signed [rmq_pkg::RMQ_DATA_W-1:0] o_quat_y,
    output logic signed [rmq_pkg::RMQ_DATA_W-1:0] o_quat_z,
    output logic signed [rmq_pkg::RMQ_DATA_W-1:0] o_quat_w,
    // APB configuration port
    input  logic                                  psel,
    input  logic                                  penable,
    input  logic                                  pwrite,
    input  logic [2:0]                            paddr,
    input  logic [31:0]                           pwdata,
    output logic [31:0]                           prdata,
    output logic                                  pready
);
    import rmq_pkg::*;

    // Unsigned clamped radicand, square root and divisor widths
    localparam int RAD_W  = ((FRAC_BITS > 15) ? FRAC_BITS : 15) + 2;
    localparam int ROOT_W = (RAD_W + FRAC_BITS + 1) / 2;
    localparam int S_W    = ROOT_W + 1;
    localparam int FIFO_W = $bits(t_job) + RAD_W;

    localparam logic REG_TRACE_EPS = 1'b0;

    // Configuration register
    logic [RMQ_EPS_W-1:0] r_eps;

    assign pready = 1'b1;
    assign prdata = (paddr[2] == REG_TRACE_EPS) ? 32'(r_eps) : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_eps <= RMQ_EPS_W'(1);
        end else if (psel && penable && pwrite && pready && paddr[2] == REG_TRACE_EPS) begin
            r_eps <= pwdata[RMQ_EPS_W-1:0];
        end
    end

    // Front: classify and form radicand and numerators
    logic             fr_valid, fr_ready;
    t_job             fr_job;
    logic [RAD_W-1:0] fr_rad;

    rmq_front #(
        .FRAC_BITS (FRAC_BITS),
        .RAD_W     (RAD_W)
    ) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .i_m11   (i_m11),
        .i_m12   (i_m12),
        .i_m13   (i_m13),
        .i_m21   (i_m21),
        .i_m22   (i_m22),
        .i_m23   (i_m23),
        .i_m31   (i_m31),
        .i_m32   (i_m32),
        .i_m33   (i_m33),
        .i_eps   (r_eps),
        .o_valid (fr_valid),
        .i_ready (fr_ready),
        .o_job   (fr_job),
        .o_rad   (fr_rad)
    );

    // Queue between front and back
    logic              q_full, q_empty, q_push, q_pop, en;
    logic [FIFO_W-1:0] q_data;
    t_job              bk_job;
    logic [RAD_W-1:0]  bk_rad;

    assign fr_ready         = !q_full;
    assign q_push           = fr_valid && !q_full;
    assign q_pop            = en && !q_empty;
    assign {bk_job, bk_rad} = q_data;

    rmq_fifo #(
        .DATA_W (FIFO_W),
        .DEPTH  (RMQ_FIFO_DEPTH)
    ) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_data  ({fr_job, fr_rad}),
        .i_pop   (q_pop),
        .o_data  (q_data),
        .o_full  (q_full),
        .o_empty (q_empty)
    );

    // Back: square root pipeline, then divider. Advance whenever the
    // output register is free or being taken.
    logic              r_ov;
    logic              sq_valid;
    t_job              sq_job;
    logic [ROOT_W-1:0] sq_root;

    assign en = !r_ov || i_ready;

    rmq_sqrt #(
        .FRAC_BITS (FRAC_BITS),
        .RAD_W     (RAD_W),
        .ROOT_W    (ROOT_W)
    ) u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (!q_empty),
        .i_job   (bk_job),
        .i_rad   (bk_rad),
        .o_valid (sq_valid),
        .o_job   (sq_job),
        .o_root  (sq_root)
    );

    // S = 2*root; the diagonal component S/4 is root/2, saturated
    logic [ROOT_W-1:0] half;
    t_tag              sq_tag;
    t_num              sq_num [3];

    assign half          = sq_root >> 1;
    assign sq_tag.branch = sq_job.branch;
    assign sq_tag.diag   = (int'(half) > 32767) ? RMQ_Q_MAX : $signed(RMQ_DATA_W'(half));
    assign sq_num[0]     = sq_job.n0;
    assign sq_num[1]     = sq_job.n1;
    assign sq_num[2]     = sq_job.n2;

    logic                         dv_valid;
    t_tag                         dv_tag;
    logic signed [RMQ_DATA_W-1:0] dv_quo [3];

    rmq_div #(
        .FRAC_BITS (FRAC_BITS),
        .S_W       (S_W)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (sq_valid),
        .i_tag   (sq_tag),
        .i_s     ({sq_root, 1'b0}),
        .i_num   (sq_num),
        .o_valid (dv_valid),
        .o_tag   (dv_tag),
        .o_quo   (dv_quo)
    );

    // Route quotients and the diagonal term to their components
    logic signed [RMQ_DATA_W-1:0] qx, qy, qz, qw;

    always_comb begin
        case (dv_tag.branch)
            BR_TRACE: begin
                qx = dv_quo[0];
                qy = dv_quo[1];
                qz = dv_quo[2];
                qw = dv_tag.diag;
            end
            BR_XMAJ: begin
                qx = dv_tag.diag;
                qy = dv_quo[0];
                qz = dv_quo[1];
                qw = dv_quo[2];
            end
            BR_YMAJ: begin
                qx = dv_quo[0];
                qy = dv_tag.diag;
                qz = dv_quo[1];
                qw = dv_quo[2];
            end
            default: begin
                qx = dv_quo[0];
                qy = dv_quo[1];
                qz = dv_tag.diag;
                qw = dv_quo[2];
            end
        endcase
    end

    // Output register: hold the result until taken
    logic signed [RMQ_DATA_W-1:0] r_qx, r_qy, r_qz, r_qw;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (en) begin
            r_ov <= dv_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en && dv_valid) begin
            r_qx <= qx;
            r_qy <= qy;
            r_qz <= qz;
            r_qw <= qw;
        end
    end

    assign o_valid  = r_ov;
    assign o_quat_x = r_qx;
    assign o_quat_y = r_qy;
    assign o_quat_z = r_qz;
    assign o_quat_w = r_qw;
endmodule
`default_nettype wire

>>> sim/rotation_matrix_to_quaternion_core_tb.sv
`default_nettype none
module rotation_matrix_to_quaternion_core_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import rmq_pkg::*;

    localparam int ONE_Q   = 1 << RMQ_FRAC_BITS;
    localparam int LATENCY = 40;

    typedef logic signed [RMQ_DATA_W-1:0] t_q;

    // One matrix request and one quaternion result
    typedef struct {
        t_q m11, m12, m13, m21, m22, m23, m31, m32, m33;
    } t_matrix;

    typedef struct {
        t_q x, y, z, w;
    } t_quat;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_valid;
    logic        o_ready;
    t_q          i_m11, i_m12, i_m13, i_m21, i_m22, i_m23, i_m31, i_m32, i_m33;
    logic        o_valid;
    logic        i_ready;
    t_q          o_quat_x, o_quat_y, o_quat_z, o_quat_w;
    logic        psel, penable, pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    rotation_matrix_to_quaternion_core dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(i_valid), .o_ready(o_ready),
        .i_m11(i_m11), .i_m12(i_m12), .i_m13(i_m13),
        .i_m21(i_m21), .i_m22(i_m22), .i_m23(i_m23),
        .i_m31(i_m31), .i_m32(i_m32), .i_m33(i_m33),
        .o_valid(o_valid), .i_ready(i_ready),
        .o_quat_x(o_quat_x), .o_quat_y(o_quat_y), .o_quat_z(o_quat_z), .o_quat_w(o_quat_w),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    localparam logic [2:0] ADDR_TRACE_EPS = 3'd0;

    // 20 ns clock
    always begin
        i_clk = 1'b1;
        #10;
        i_clk = 1'b0;
        #10;
    end

    t_matrix      pending_mats[$];
    t_quat        expected_quats[$];
    int           error_count;
    int unsigned  tb_eps;
    int unsigned  drv_gap;
    int unsigned  mon_gap;

    // Gap lengths: mostly none, often short, now and then long
    function automatic int unsigned pick_gap();
        int unsigned r;
        r = $urandom_range(99);
        if (r < 50)
            return 0;
        if (r < 92)
            return $urandom_range(3, 1);
        return $urandom_range(40, 8);
    endfunction

    // floor(sqrt(v)), bitwise
    function automatic longint unsigned int_root(longint unsigned v);
        longint unsigned res;
        longint unsigned bitv;
        res  = 0;
        bitv = 64'd1 << 62;
        while (bitv > v)
            bitv >>= 2;
        while (bitv != 0) begin
            if (v >= res + bitv) begin
                v   = v - (res + bitv);
                res = (res >> 1) + bitv;
            end else begin
                res >>= 1;
            end
            bitv >>= 2;
        end
        return res;
    endfunction

    // 2*sqrt(r) in Q units; a non-positive radicand gives zero
    function automatic longint unsigned scale_of(longint r);
        if (r <= 0)
            return 0;
        return 2 * int_root(longint'(r) << RMQ_FRAC_BITS);
    endfunction

    // (num * ONE) / s truncated toward zero; zero divisor gives zero
    function automatic longint quot_q(longint num, longint unsigned s);
        longint unsigned mag;
        longint unsigned q;
        if (s == 0)
            return 0;
        mag = (num < 0) ? longint'(-num) : num;
        q   = (mag << RMQ_FRAC_BITS) / s;
        return (num < 0) ? -longint'(q) : longint'(q);
    endfunction

    function automatic t_q clip16(longint v);
        if (v > 32767)
            return RMQ_Q_MAX;
        if (v < -32768)
            return RMQ_Q_MIN;
        return t_q'(v);
    endfunction

    function automatic t_quat matrix_to_quat(t_matrix m, int unsigned eps);
        longint a11, a12, a13, a21, a22, a23, a31, a32, a33;
        longint tr, x, y, z, w;
        longint unsigned s;
        t_quat q;
        a11 = m.m11; a12 = m.m12; a13 = m.m13;
        a21 = m.m21; a22 = m.m22; a23 = m.m23;
        a31 = m.m31; a32 = m.m32; a33 = m.m33;
        tr = ONE_Q + a11 + a22 + a33;
        if (tr > longint'(eps)) begin
            s = scale_of(tr);
            x = quot_q(a12 - a21, s);
            y = quot_q(a31 - a13, s);
            z = quot_q(a23 - a32, s);
            w = longint'(s >> 2);
        end else if (a11 > a22 && a11 > a33) begin
            s = scale_of(ONE_Q + a11 - a22 - a33);
            x = longint'(s >> 2);
            y = quot_q(a12 + a21, s);
            z = quot_q(a31 + a13, s);
            w = quot_q(a23 - a32, s);
        end else if (a22 > a33) begin
            s = scale_of(ONE_Q + a22 - a11 - a33);
            x = quot_q(a12 + a21, s);
            y = longint'(s >> 2);
            z = quot_q(a23 + a32, s);
            w = quot_q(a31 - a13, s);
        end else begin
            s = scale_of(ONE_Q + a33 - a11 - a22);
            x = quot_q(a31 + a13, s);
            y = quot_q(a23 + a32, s);
            z = longint'(s >> 2);
            w = quot_q(a12 - a21, s);
        end
        q.x = clip16(x);
        q.y = clip16(y);
        q.z = clip16(z);
        q.w = clip16(w);
        return q;
    endfunction

    task automatic report_mismatch(string what, t_q got, t_q want);
        $display("mismatch on %s: got %0d, expected %0d at %0t", what, got, want, $realtime);
        error_count++;
    endtask

    // Request driver: pull from the pending queue, insert gaps, hold until accepted
    always @(posedge i_clk) begin
        t_matrix m;
        if (!i_rst_n) begin
            i_valid <= 1'b0;
            drv_gap <= 0;
        end else begin
            if (i_valid && o_ready) begin
                m = pending_mats.pop_front();
                expected_quats.push_back(matrix_to_quat(m, tb_eps));
            end
            if (!i_valid || o_ready) begin
                if (drv_gap != 0) begin
                    drv_gap <= drv_gap - 1;
                    i_valid <= 1'b0;
                end else if (pending_mats.size() != 0) begin
                    // peek the next item still waiting
                    m = pending_mats[0];
                    i_valid <= 1'b1;
                    i_m11 <= m.m11; i_m12 <= m.m12; i_m13 <= m.m13;
                    i_m21 <= m.m21; i_m22 <= m.m22; i_m23 <= m.m23;
                    i_m31 <= m.m31; i_m32 <= m.m32; i_m33 <= m.m33;
                    drv_gap <= pick_gap();
                end else begin
                    i_valid <= 1'b0;
                end
            end
        end
    end

    // Result monitor: stall at random, check each accepted result in order
    always @(posedge i_clk) begin
        t_quat e;
        if (!i_rst_n) begin
            i_ready <= 1'b0;
            mon_gap <= 0;
        end else begin
            if (o_valid && i_ready) begin
                if (expected_quats.size() == 0) begin
                    $display("unexpected result at %0t", $realtime);
                    error_count++;
                end else begin
                    e = expected_quats.pop_front();
                    if (o_quat_x !== e.x) report_mismatch("quat_x", o_quat_x, e.x);
                    if (o_quat_y !== e.y) report_mismatch("quat_y", o_quat_y, e.y);
                    if (o_quat_z !== e.z) report_mismatch("quat_z", o_quat_z, e.z);
                    if (o_quat_w !== e.w) report_mismatch("quat_w", o_quat_w, e.w);
                end
            end
            if (mon_gap != 0) begin
                mon_gap <= mon_gap - 1;
                i_ready <= 1'b0;
            end else begin
                i_ready <= 1'b1;
                mon_gap <= pick_gap();
            end
        end
    end

    function automatic t_q rand_q();
        return t_q'($urandom_range(65535));
    endfunction

    // Element near a rotation matrix value: within one unit
    function automatic t_q near_unit();
        return t_q'($signed($urandom_range(2 * ONE_Q)) - ONE_Q);
    endfunction

    function automatic t_matrix rand_matrix();
        t_matrix m;
        int unsigned kind;
        kind = $urandom_range(9);
        if (kind < 6) begin
            // well-formed-ish: values in [-1, 1]
            m.m11 = near_unit(); m.m12 = near_unit(); m.m13 = near_unit();
            m.m21 = near_unit(); m.m22 = near_unit(); m.m23 = near_unit();
            m.m31 = near_unit(); m.m32 = near_unit(); m.m33 = near_unit();
            if (kind < 3) begin
                // drive the trace low so the major-axis branches are taken
                m.m11 = t_q'(-$signed(33'($urandom_range(ONE_Q))));
                m.m22 = t_q'(-$signed(33'($urandom_range(ONE_Q))));
                m.m33 = t_q'(-$signed(33'($urandom_range(ONE_Q))));
                case ($urandom_range(2))
                    0: m.m11 = near_unit();
                    1: m.m22 = near_unit();
                    default: m.m33 = near_unit();
                endcase
            end
        end else begin
            m.m11 = rand_q(); m.m12 = rand_q(); m.m13 = rand_q();
            m.m21 = rand_q(); m.m22 = rand_q(); m.m23 = rand_q();
            m.m31 = rand_q(); m.m32 = rand_q(); m.m33 = rand_q();
        end
        return m;
    endfunction

    function automatic t_matrix diag_matrix(t_q d1, t_q d2, t_q d3, t_q off);
        t_matrix m;
        m.m11 = d1;  m.m12 = off; m.m13 = -off;
        m.m21 = -off; m.m22 = d2; m.m23 = off;
        m.m31 = off; m.m32 = -off; m.m33 = d3;
        return m;
    endfunction

    task automatic apb_write(logic [2:0] addr, logic [31:0] data);
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready)
            @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        // mirror the register, masked to its width
        tb_eps = data & 32'h3FFF;
    endtask

    // Hold until every request has gone in and every result has come back
    task automatic drain();
        while (pending_mats.size() != 0 || expected_quats.size() != 0)
            @(posedge i_clk);
        repeat (LATENCY) @(posedge i_clk);
    endtask

    task automatic run_phase(int unsigned n);
        repeat (n) pending_mats.push_back(rand_matrix());
        drain();
    endtask

    initial begin
        t_matrix m;
        int unsigned eps_set[5];
        error_count = 0;
        tb_eps      = 1;
        i_rst_n     = 1'b0;
        i_valid     = 1'b0;
        i_ready     = 1'b0;
        {i_m11, i_m12, i_m13, i_m21, i_m22, i_m23, i_m31, i_m32, i_m33} = '0;
        psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: identity, each major axis, ties, extremes, zero radicand
        pending_mats.push_back(diag_matrix(16'sd16384, 16'sd16384, 16'sd16384, 16'sd0));
        pending_mats.push_back(diag_matrix(16'sd16384, -16'sd16384, -16'sd16384, 16'sd100));
        pending_mats.push_back(diag_matrix(-16'sd16384, 16'sd16384, -16'sd16384, 16'sd200));
        pending_mats.push_back(diag_matrix(-16'sd16384, -16'sd16384, 16'sd16384, -16'sd300));
        pending_mats.push_back(diag_matrix(-16'sd8192, -16'sd8192, -16'sd8192, 16'sd500));
        pending_mats.push_back(diag_matrix(-16'sd16384, -16'sd16384, -16'sd16384, 16'sd0));
        pending_mats.push_back(diag_matrix(RMQ_Q_MIN, RMQ_Q_MIN, RMQ_Q_MIN, RMQ_Q_MAX));
        pending_mats.push_back(diag_matrix(RMQ_Q_MAX, RMQ_Q_MAX, RMQ_Q_MAX, RMQ_Q_MIN));
        pending_mats.push_back(diag_matrix(RMQ_Q_MAX, RMQ_Q_MIN, RMQ_Q_MIN, RMQ_Q_MAX));
        pending_mats.push_back(diag_matrix(RMQ_Q_MIN, RMQ_Q_MAX, RMQ_Q_MIN, RMQ_Q_MIN));
        pending_mats.push_back(diag_matrix(RMQ_Q_MIN, RMQ_Q_MIN, RMQ_Q_MAX, RMQ_Q_MAX));
        // trace exactly at the threshold (tr == 1) falls to the axis branches
        pending_mats.push_back(diag_matrix(-16'sd16383, 16'sd0, 16'sd0, 16'sd7));
        pending_mats.push_back(diag_matrix(-16'sd16382, 16'sd0, 16'sd0, 16'sd7));
        // ties between diagonal elements fall to the later branch
        pending_mats.push_back(diag_matrix(-16'sd10000, -16'sd10000, -16'sd12000, 16'sd9));
        pending_mats.push_back(diag_matrix(-16'sd10000, -16'sd12000, -16'sd10000, 16'sd9));
        // zero trace with full-scale off-diagonal terms
        pending_mats.push_back(diag_matrix(-16'sd5461, -16'sd5461, -16'sd5462, RMQ_Q_MAX));
        pending_mats.push_back(diag_matrix(16'sd0, 16'sd0, 16'sd0, 16'sd0));
        pending_mats.push_back(diag_matrix(16'sd0, 16'sd0, 16'sd0, 16'sd0));
        pending_mats.push_back(diag_matrix(-16'sd1, -16'sd1, -16'sd1, -16'sd1));
        drain();

        // Random phases across several thresholds, extremes included
        eps_set[0] = 0;
        eps_set[1] = 16383;
        eps_set[2] = 1;
        eps_set[3] = $urandom_range(16383);
        eps_set[4] = 8192;
        foreach (eps_set[k]) begin
            apb_write(ADDR_TRACE_EPS, (k == 3) ? $urandom() : eps_set[k]);
            run_phase(206);
        end

        if (error_count == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

    initial begin
        #(20ms);
        $display("FAILURE");
        $finish;
    end
endmodule
`default_nettype wire
